// ===== hdl/cpc_pkg.sv =====
// ----------------------------------------------------------------------------
// cpc_pkg: cascaded PI controller package
// Shared widths, register codes, sequencer states and a saturation helper.
// ----------------------------------------------------------------------------
package cpc_pkg;

  localparam int unsigned DataW    = 32;
  localparam int unsigned GainFrac = 24;
  localparam int unsigned RegIdxW  = 3;

  typedef logic signed [DataW-1:0] q_t;
  typedef logic signed [DataW+1:0] q_wide_t;

  localparam q_t DriveMaxRst = 32'sd131072;
  localparam q_t DriveMinRst = -32'sd131072;

  typedef enum logic [RegIdxW-1:0] {
    REG_ANGLE_KP      = 3'd0,
    REG_ANGLE_KI_STEP = 3'd1,
    REG_SPEED_KP      = 3'd2,
    REG_SPEED_KI_STEP = 3'd3,
    REG_COMP_GAIN     = 3'd4,
    REG_DRIVE_MAX     = 3'd5,
    REG_DRIVE_MIN     = 3'd6
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EANG,   // angle error
    ST_MKP,    // issue e_ang * angle_kp
    ST_MKI,    // issue e_ang * angle_ki_step
    ST_DIFF,   // limited - raw of last tick, capture outer P term
    ST_AINT,   // outer integral update
    ST_SPSET,  // speed setpoint
    ST_ESPD,   // speed error
    ST_MSKP,   // issue e_spd * speed_kp
    ST_MSKI,   // issue e_spd * speed_ki_step
    ST_MCG,    // issue diff * comp_gain, capture inner P term
    ST_SINT,   // inner integral update
    ST_WIND,   // anti-windup accumulator update
    ST_RAW,    // three-term raw drive
    ST_CLAMP   // clamp and publish
  } cpc_state_e;

  // saturate a 34-bit exact sum to signed 32 bits
  function automatic q_t sat_sum(input q_wide_t v);
    q_t r;
    if ((v[DataW+1:DataW-1] == 3'b000) || (v[DataW+1:DataW-1] == 3'b111)) begin
      r = v[DataW-1:0];
    end else if (v[DataW+1]) begin
      r = {1'b1, {(DataW-1){1'b0}}};
    end else begin
      r = {1'b0, {(DataW-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

// ===== hdl/cpc_if.sv =====
// ----------------------------------------------------------------------------
// cpc_if: channel interfaces
// Valid/ready channels for setpoint/feedback items, result items and
// register writes.
// ----------------------------------------------------------------------------
interface cpc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] angle_target;
  logic [31:0] angle_measured;
  logic [31:0] speed_measured;

  modport source (output valid, angle_target, angle_measured, speed_measured,
                  input ready);
  modport sink   (input valid, angle_target, angle_measured, speed_measured,
                  output ready);
endinterface

interface cpc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] drive_out;
  logic [31:0] speed_target;
  logic        drive_clamped;

  modport source (output valid, drive_out, speed_target, drive_clamped,
                  input ready);
  modport sink   (input valid, drive_out, speed_target, drive_clamped,
                   output ready);
endinterface

interface cpc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/cpc_mul.sv =====
// ----------------------------------------------------------------------------
// cpc_mul: shared gain multiplier
// Q16.16 x Q8.24 product, floor shift by 24, saturate; product and result are registered.
// ----------------------------------------------------------------------------
module cpc_mul import cpc_pkg::*; (
  input  logic clk_i,
  input  q_t   x_i,
  input  q_t   g_i,
  output q_t   r_o
);

  logic signed [2*DataW-1:0] prod_q;
  q_t                        res_q;
  logic [DataW-GainFrac:0]   top_bits;  // bits that must all match the sign
  q_t                        res_d;

  always_comb begin
    top_bits = prod_q[2*DataW-1:DataW+GainFrac-1];
    if ((top_bits == '0) || (top_bits == '1)) begin
      res_d = prod_q[DataW+GainFrac-1:GainFrac];
    end else if (prod_q[2*DataW-1]) begin
      res_d = {1'b1, {(DataW-1){1'b0}}};
    end else begin
      res_d = {1'b0, {(DataW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= x_i * g_i;
    res_q  <= res_d;
  end

  assign r_o = res_q;

endmodule

// ===== hdl/cascaded_pi_position_speed_control_core.sv =====
// ----------------------------------------------------------------------------
// cascaded_pi_position_speed_control_core: cascaded PI position/speed loop
// Outer angle PI feeding an inner speed PI with back-calculation anti-windup
// and drive clamp, built around one shared multiplier and one shared adder.
// ----------------------------------------------------------------------------
// One item is one control tick: angle setpoint, measured angle and measured
// speed (Q16.16). The block answers each item with one result item holding the
// clamped drive, the outer-loop speed setpoint and a clamp flag. An item is
// taken only while the sequencer is idle; it then runs 14 steps, one per clock,
// through a single saturating three-input adder and a single two-stage
// 32x32 multiplier (five gain products per tick), so a new item is only
// accepted after the sequencer has returned to idle. The result sits in
// an output register; if it has not been taken by the time the next tick
// finishes, the sequencer holds in its last step. Gains are Q8.24; products
// are floored back to Q16.16 and every sum saturates to 32 bits. The user must
// write registers through the configuration channel (always ready) only while
// no item is in flight; the block does not enforce this. An index past the last register is dropped.
// ----------------------------------------------------------------------------
module cascaded_pi_position_speed_control_core import cpc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  cpc_cfg_if.sink   cfg_i,
  cpc_in_if.sink    in_i,
  cpc_out_if.source out_o
);

  cpc_state_e state_q, state_d;

  // configuration
  q_t angle_kp_q, angle_ki_q, speed_kp_q, speed_ki_q, comp_gain_q;
  q_t drive_max_q, drive_min_q;

  // loop state
  q_t aint_q, sint_q, wind_q, last_raw_q, last_lim_q;

  // per-tick working registers (payload, no reset)
  q_t tgt_q, ang_q, spd_q, err_q, diff_q, pang_q, pspd_q, spdset_q, raw_q;

  // result register
  logic out_valid_q;
  q_t   drive_q, spdo_q;
  logic clamp_q;

  // shared units
  q_t      add_a, add_b, add_c, add_r;
  logic    add_neg;
  q_wide_t ext_b;
  q_t      mul_x, mul_g, mul_r;
  logic    advance;

  cpc_mul u_mul (
    .clk_i (clk_i),
    .x_i   (mul_x),
    .g_i   (mul_g),
    .r_o   (mul_r)
  );

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = (state_q == ST_IDLE);

  assign out_o.valid         = out_valid_q;
  assign out_o.drive_out     = drive_q;
  assign out_o.speed_target  = spdo_q;
  assign out_o.drive_clamped = clamp_q;

  // publish only once the previous result is gone or leaves this cycle
  assign advance = !out_valid_q || out_o.ready;

  // saturating adder: a +/- b + c, exact in 34 bits
  always_comb begin
    ext_b = {{2{add_b[DataW-1]}}, add_b};
    if (add_neg) begin
      ext_b = -ext_b;
    end
    add_r = sat_sum({{2{add_a[DataW-1]}}, add_a} + ext_b
                    + {{2{add_c[DataW-1]}}, add_c});
  end

  // sequencer: next state and operand selection
  always_comb begin
    state_d = state_q;
    add_a   = '0;
    add_b   = '0;
    add_c   = '0;
    add_neg = 1'b0;
    mul_x   = err_q;
    mul_g   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          state_d = ST_EANG;
        end
      end
      ST_EANG: begin
        add_a   = tgt_q;
        add_b   = ang_q;
        add_neg = 1'b1;
        state_d = ST_MKP;
      end
      ST_MKP: begin
        mul_g   = angle_kp_q;
        state_d = ST_MKI;
      end
      ST_MKI: begin
        mul_g   = angle_ki_q;
        state_d = ST_DIFF;
      end
      ST_DIFF: begin
        add_a   = last_lim_q;
        add_b   = last_raw_q;
        add_neg = 1'b1;
        state_d = ST_AINT;
      end
      ST_AINT: begin
        add_a   = aint_q;
        add_b   = mul_r;
        state_d = ST_SPSET;
      end
      ST_SPSET: begin
        add_a   = pang_q;
        add_b   = aint_q;
        state_d = ST_ESPD;
      end
      ST_ESPD: begin
        add_a   = spdset_q;
        add_b   = spd_q;
        add_neg = 1'b1;
        state_d = ST_MSKP;
      end
      ST_MSKP: begin
        mul_g   = speed_kp_q;
        state_d = ST_MSKI;
      end
      ST_MSKI: begin
        mul_g   = speed_ki_q;
        state_d = ST_MCG;
      end
      ST_MCG: begin
        mul_x   = diff_q;
        mul_g   = comp_gain_q;
        state_d = ST_SINT;
      end
      ST_SINT: begin
        add_a   = sint_q;
        add_b   = mul_r;
        state_d = ST_WIND;
      end
      ST_WIND: begin
        add_a   = wind_q;
        add_b   = mul_r;
        state_d = ST_RAW;
      end
      ST_RAW: begin
        add_a   = pspd_q;
        add_b   = sint_q;
        add_c   = wind_q;
        state_d = ST_CLAMP;
      end
      ST_CLAMP: begin
        if (advance) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // configuration, loop state and result handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_kp_q  <= '0;
      angle_ki_q  <= '0;
      speed_kp_q  <= '0;
      speed_ki_q  <= '0;
      comp_gain_q <= '0;
      drive_max_q <= DriveMaxRst;
      drive_min_q <= DriveMinRst;
      aint_q      <= '0;
      sint_q      <= '0;
      wind_q      <= '0;
      last_raw_q  <= '0;
      last_lim_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        unique case (cfg_i.index)
          REG_ANGLE_KP:      angle_kp_q  <= cfg_i.data;
          REG_ANGLE_KI_STEP: angle_ki_q  <= cfg_i.data;
          REG_SPEED_KP:      speed_kp_q  <= cfg_i.data;
          REG_SPEED_KI_STEP: speed_ki_q  <= cfg_i.data;
          REG_COMP_GAIN:     comp_gain_q <= cfg_i.data;
          REG_DRIVE_MAX:     drive_max_q <= cfg_i.data;
          REG_DRIVE_MIN:     drive_min_q <= cfg_i.data;
          default: ;
        endcase
      end

      if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_AINT: aint_q <= add_r;
        ST_SINT: sint_q <= add_r;
        ST_WIND: wind_q <= add_r;
        ST_CLAMP: begin
          if (advance) begin
            out_valid_q <= 1'b1;
            last_raw_q  <= raw_q;
            // upper test first, so with inverted limits a value above drive_max gives drive_max
            if (raw_q > drive_max_q) begin
              last_lim_q <= drive_max_q;
            end else if (raw_q < drive_min_q) begin
              last_lim_q <= drive_min_q;
            end else begin
              last_lim_q <= raw_q;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // working registers and result payload
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        tgt_q <= in_i.angle_target;
        ang_q <= in_i.angle_measured;
        spd_q <= in_i.speed_measured;
      end
      ST_EANG:  err_q    <= add_r;
      ST_DIFF: begin
        diff_q <= add_r;
        pang_q <= mul_r;
      end
      ST_SPSET: spdset_q <= add_r;
      ST_ESPD:  err_q    <= add_r;
      ST_MCG:   pspd_q   <= mul_r;
      ST_RAW:   raw_q    <= add_r;
      ST_CLAMP: begin
        if (advance) begin
          spdo_q <= spdset_q;
          if (raw_q > drive_max_q) begin
            drive_q <= drive_max_q;
            clamp_q <= 1'b1;
          end else if (raw_q < drive_min_q) begin
            drive_q <= drive_min_q;
            clamp_q <= 1'b1;
          end else begin
            drive_q <= raw_q;
            clamp_q <= 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

endmodule
